/* design/sst_pkg.sv */
// shared types, token codes and keyword tables for the script tokenizer
`timescale 1ns / 1ps

package sst_pkg;

    localparam int POSITION_BITS_DEF = 32;
    localparam int PORT_POS_BITS     = 32;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_WORD   = 3'd1,
        MODE_QUOTED = 3'd2,
        MODE_IDENT  = 3'd3,
        MODE_NUMBER = 3'd4,
        MODE_ERROR  = 3'd5
    } lex_mode_t;

    typedef logic [3:0] tok_kind_t;

    localparam tok_kind_t TOK_LBRACKET  = 4'd0;
    localparam tok_kind_t TOK_RBRACKET  = 4'd1;
    localparam tok_kind_t TOK_COMMA     = 4'd2;
    localparam tok_kind_t TOK_EQUALS    = 4'd3;
    localparam tok_kind_t TOK_NEWLINE   = 4'd4;
    localparam tok_kind_t TOK_NUMBER    = 4'd5;
    localparam tok_kind_t TOK_QUOTED    = 4'd6;
    localparam tok_kind_t TOK_WORD      = 4'd7;
    localparam tok_kind_t TOK_IDENT     = 4'd8;
    localparam tok_kind_t TOK_VARIABLES = 4'd9;
    localparam tok_kind_t TOK_EVENTS    = 4'd10;
    localparam tok_kind_t TOK_ERROR     = 4'd11;

    localparam logic [3:0] VARIABLES_LEN = 4'd9;
    localparam logic [3:0] EVENTS_LEN    = 4'd6;
    localparam logic [3:0] WORD_LEN_MAX  = 4'd15;

    // letter of "Variables" at index i
    function automatic logic [7:0] kw_variables_char(input logic [3:0] i);
        logic [7:0] ch;
        case (i)
            4'd0:    ch = "V";
            4'd1:    ch = "a";
            4'd2:    ch = "r";
            4'd3:    ch = "i";
            4'd4:    ch = "a";
            4'd5:    ch = "b";
            4'd6:    ch = "l";
            4'd7:    ch = "e";
            4'd8:    ch = "s";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // letter of "Events" at index i
    function automatic logic [7:0] kw_events_char(input logic [3:0] i);
        logic [7:0] ch;
        case (i)
            4'd0:    ch = "E";
            4'd1:    ch = "v";
            4'd2:    ch = "e";
            4'd3:    ch = "n";
            4'd4:    ch = "t";
            4'd5:    ch = "s";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic tok_kind_t word_kind(input logic [3:0] len, input logic mv,
                                            input logic me);
        tok_kind_t k;
        if (mv && len == VARIABLES_LEN) begin
            k = TOK_VARIABLES;
        end else if (me && len == EVENTS_LEN) begin
            k = TOK_EVENTS;
        end else begin
            k = TOK_WORD;
        end
        return k;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

endpackage

/* design/sst_lexer.sv */
// lexer state and per-byte token decode, up to two tokens per byte
`timescale 1ns / 1ps

module sst_lexer #(
    parameter int POSITION_BITS = sst_pkg::POSITION_BITS_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     advance,
    input  logic [7:0]                               source_byte,
    input  logic                                     end_of_source,
    output logic [1:0]                               res_count,
    output sst_pkg::tok_kind_t [1:0]                 res_kind,
    output logic [1:0][POSITION_BITS-1:0]            res_start,
    output logic [1:0][POSITION_BITS-1:0]            res_end
);

    localparam int P = POSITION_BITS;
    localparam logic [P-1:0] PosMax = '1;

    sst_pkg::lex_mode_t mode_reg, mode_next;
    logic [P-1:0]       begin_reg, begin_next;
    logic [P-1:0]       pos_reg, pos_next;
    logic [3:0]         wlen_reg, wlen_next;
    logic               mv_reg, mv_next;
    logic               me_reg, me_next;

    logic [P:0]   sum1, sum2;
    logic [P-1:0] pos_one, pos_two;

    // token closed by this byte, single-character token, end-of-source flush
    logic               close_v, beg_v, flush_v;
    sst_pkg::tok_kind_t close_kind, beg_kind, flush_kind;
    logic [P-1:0]       close_end, flush_end, flush_start;
    sst_pkg::lex_mode_t mode_mid;
    logic               consumed;
    // word state after this byte, before the end-of-source clear
    logic [3:0]         wlen_mid;
    logic               mv_mid, me_mid;

    assign sum1    = {1'b0, pos_reg} + (P+1)'(1);
    assign sum2    = {1'b0, pos_reg} + (P+1)'(2);
    assign pos_one = sum1[P] ? PosMax : sum1[P-1:0];
    assign pos_two = sum2[P] ? PosMax : sum2[P-1:0];

    // next state and the tokens of this byte
    always_comb begin
        mode_mid   = mode_reg;
        begin_next = begin_reg;
        wlen_next  = wlen_reg;
        mv_next    = mv_reg;
        me_next    = me_reg;
        consumed   = 1'b0;
        close_v    = 1'b0;
        close_kind = sst_pkg::TOK_WORD;
        close_end  = pos_reg;
        beg_v      = 1'b0;
        beg_kind   = sst_pkg::TOK_ERROR;

        case (mode_reg)
            sst_pkg::MODE_ERROR: begin
                consumed = 1'b1;
            end
            sst_pkg::MODE_QUOTED: begin
                consumed = 1'b1;
                if (source_byte == "\"") begin
                    close_v    = 1'b1;
                    close_kind = sst_pkg::TOK_QUOTED;
                    close_end  = pos_one;
                    mode_mid   = sst_pkg::MODE_IDLE;
                end
            end
            sst_pkg::MODE_WORD: begin
                if (sst_pkg::is_alpha(source_byte)) begin
                    consumed = 1'b1;
                    if (wlen_reg >= sst_pkg::VARIABLES_LEN ||
                        sst_pkg::kw_variables_char(wlen_reg) != source_byte) begin
                        mv_next = 1'b0;
                    end
                    if (wlen_reg >= sst_pkg::EVENTS_LEN ||
                        sst_pkg::kw_events_char(wlen_reg) != source_byte) begin
                        me_next = 1'b0;
                    end
                    if (wlen_reg < sst_pkg::WORD_LEN_MAX) begin
                        wlen_next = wlen_reg + 4'd1;
                    end
                end else begin
                    close_v    = 1'b1;
                    close_kind = sst_pkg::word_kind(wlen_reg, mv_reg, me_reg);
                    mode_mid   = sst_pkg::MODE_IDLE;
                end
            end
            sst_pkg::MODE_IDENT: begin
                if (sst_pkg::is_alpha(source_byte) || sst_pkg::is_digit(source_byte)) begin
                    consumed = 1'b1;
                end else begin
                    close_v    = 1'b1;
                    close_kind = sst_pkg::TOK_IDENT;
                    mode_mid   = sst_pkg::MODE_IDLE;
                end
            end
            sst_pkg::MODE_NUMBER: begin
                if (sst_pkg::is_digit(source_byte) || source_byte == ".") begin
                    consumed = 1'b1;
                end else begin
                    close_v    = 1'b1;
                    close_kind = sst_pkg::TOK_NUMBER;
                    mode_mid   = sst_pkg::MODE_IDLE;
                end
            end
            default: begin
                mode_mid = sst_pkg::MODE_IDLE;
            end
        endcase

        if (!consumed) begin
            if (source_byte == "[") begin
                beg_v = 1'b1; beg_kind = sst_pkg::TOK_LBRACKET;
            end else if (source_byte == "]") begin
                beg_v = 1'b1; beg_kind = sst_pkg::TOK_RBRACKET;
            end else if (source_byte == ",") begin
                beg_v = 1'b1; beg_kind = sst_pkg::TOK_COMMA;
            end else if (source_byte == "=") begin
                beg_v = 1'b1; beg_kind = sst_pkg::TOK_EQUALS;
            end else if (source_byte == 8'h0A) begin
                beg_v = 1'b1; beg_kind = sst_pkg::TOK_NEWLINE;
            end else if (sst_pkg::is_digit(source_byte)) begin
                mode_mid   = sst_pkg::MODE_NUMBER;
                begin_next = pos_reg;
            end else if (source_byte == "\"") begin
                mode_mid   = sst_pkg::MODE_QUOTED;
                begin_next = pos_reg;
            end else if (sst_pkg::is_alpha(source_byte)) begin
                // first letter of a word, checked against both keywords
                mode_mid   = sst_pkg::MODE_WORD;
                begin_next = pos_reg;
                wlen_next  = 4'd1;
                mv_next    = (source_byte == sst_pkg::kw_variables_char(4'd0));
                me_next    = (source_byte == sst_pkg::kw_events_char(4'd0));
            end else if (source_byte == "$") begin
                mode_mid   = sst_pkg::MODE_IDENT;
                begin_next = pos_reg;
            end else if (source_byte == 8'h0D) begin
                // carriage return at token start is dropped
                beg_v = 1'b0;
            end else begin
                beg_v    = 1'b1;
                beg_kind = sst_pkg::TOK_ERROR;
                mode_mid = sst_pkg::MODE_ERROR;
            end
        end

        wlen_mid  = wlen_next;
        mv_mid    = mv_next;
        me_mid    = me_next;
        mode_next = mode_mid;
        pos_next  = pos_one;
        if (end_of_source) begin
            mode_next  = sst_pkg::MODE_IDLE;
            begin_next = '0;
            pos_next   = '0;
            wlen_next  = 4'd0;
            mv_next    = 1'b1;
            me_next    = 1'b1;
        end
    end

    // end-of-source flush and packing into two result slots
    always_comb begin
        flush_v     = 1'b0;
        flush_kind  = sst_pkg::TOK_WORD;
        flush_end   = pos_one;
        // a token opened by this very byte starts here
        flush_start = consumed ? begin_reg : pos_reg;
        if (end_of_source) begin
            case (mode_mid)
                sst_pkg::MODE_WORD: begin
                    flush_v    = 1'b1;
                    flush_kind = sst_pkg::word_kind(wlen_mid, mv_mid, me_mid);
                end
                sst_pkg::MODE_IDENT: begin
                    flush_v    = 1'b1;
                    flush_kind = sst_pkg::TOK_IDENT;
                end
                sst_pkg::MODE_NUMBER: begin
                    flush_v    = 1'b1;
                    flush_kind = sst_pkg::TOK_NUMBER;
                end
                sst_pkg::MODE_QUOTED: begin
                    flush_v    = 1'b1;
                    flush_kind = sst_pkg::TOK_QUOTED;
                    flush_end  = pos_two;
                end
                default: begin
                    flush_v = 1'b0;
                end
            endcase
        end

        res_kind  = {sst_pkg::TOK_WORD, sst_pkg::TOK_WORD};
        res_start = '0;
        res_end   = '0;
        res_count = 2'd0;
        // a byte that closes a token and starts a single-character one opens no token
        if (close_v) begin
            res_kind[0]  = close_kind;
            res_start[0] = begin_reg;
            res_end[0]   = close_end;
            if (beg_v) begin
                res_kind[1]  = beg_kind;
                res_start[1] = pos_reg;
                res_end[1]   = pos_one;
                res_count    = 2'd2;
            end else if (flush_v) begin
                res_kind[1]  = flush_kind;
                res_start[1] = flush_start;
                res_end[1]   = flush_end;
                res_count    = 2'd2;
            end else begin
                res_count = 2'd1;
            end
        end else if (beg_v) begin
            res_kind[0]  = beg_kind;
            res_start[0] = pos_reg;
            res_end[0]   = pos_one;
            res_count    = 2'd1;
        end else if (flush_v) begin
            res_kind[0]  = flush_kind;
            res_start[0] = flush_start;
            res_end[0]   = flush_end;
            res_count    = 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= sst_pkg::MODE_IDLE;
            begin_reg <= '0;
            pos_reg   <= '0;
            wlen_reg  <= 4'd0;
            mv_reg    <= 1'b1;
            me_reg    <= 1'b1;
        end else if (advance) begin
            mode_reg  <= mode_next;
            begin_reg <= begin_next;
            pos_reg   <= pos_next;
            wlen_reg  <= wlen_next;
            mv_reg    <= mv_next;
            me_reg    <= me_next;
        end
    end

endmodule

/* design/storyboard_script_tokenizer.sv */
// top level of the script tokenizer: lexer plus two-entry result buffer
`timescale 1ns / 1ps

// Script tokenizer, one source byte per item.
// Input channel s_*: source_byte with end_of_source set on the final byte of
// a script. Result channel m_*: one token per item, kind, start and end
// position, with m_last_of_item set on the last token caused by a byte.
// A byte is decoded in the cycle it is accepted; its tokens sit in a
// two-entry result buffer and the first shows on m_* in the next cycle.
// A byte gives zero, one or two tokens. Throughput is one byte per cycle
// while bytes give at most one token each and m_ready stays high; a byte
// that gives two tokens holds s_ready low until the first has been taken,
// since the result port moves one token per cycle.
// When the receiver stalls, buffered tokens hold and s_ready drops once the
// buffer cannot take the next byte's tokens.
// Reset (aresetn low, synchronous) empties the buffer, returns position to
// zero and closes any open token without reporting it. end_of_source also
// returns position to zero at the end of a script, after flushing the open token.
module storyboard_script_tokenizer #(
    parameter int POSITION_BITS = sst_pkg::POSITION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_source_byte,
    input  logic        s_end_of_source,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_token_kind,
    output logic [31:0] m_start_position,
    output logic [31:0] m_end_position,
    output logic        m_last_of_item
);

    localparam int P = POSITION_BITS;

    logic                           accept, pop;
    logic [1:0]                     res_count;
    sst_pkg::tok_kind_t [1:0]       res_kind;
    logic [1:0][P-1:0]              res_start, res_end;

    logic [1:0]                     cnt_reg, cnt_next;
    sst_pkg::tok_kind_t [1:0]       kind_reg, kind_next;
    logic [1:0][P-1:0]              start_reg, start_next;
    logic [1:0][P-1:0]              end_reg, end_next;
    logic [1:0]                     last_reg, last_next;

    sst_lexer #(
        .POSITION_BITS(P)
    ) u_lexer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (accept),
        .source_byte  (s_source_byte),
        .end_of_source(s_end_of_source),
        .res_count    (res_count),
        .res_kind     (res_kind),
        .res_start    (res_start),
        .res_end      (res_end)
    );

    assign m_valid = (cnt_reg != 2'd0);
    assign pop     = m_valid && m_ready;
    // a new byte may bring two tokens, so the buffer must drain to empty
    assign s_ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);
    assign accept  = s_valid && s_ready;

    assign m_token_kind     = kind_reg[0];
    assign m_start_position = sst_pkg::PORT_POS_BITS'(start_reg[0]);
    assign m_end_position   = sst_pkg::PORT_POS_BITS'(end_reg[0]);
    assign m_last_of_item   = last_reg[0];

    always_comb begin
        cnt_next   = cnt_reg;
        kind_next  = kind_reg;
        start_next = start_reg;
        end_next   = end_reg;
        last_next  = last_reg;
        if (pop) begin
            cnt_next      = cnt_reg - 2'd1;
            kind_next[0]  = kind_reg[1];
            start_next[0] = start_reg[1];
            end_next[0]   = end_reg[1];
            last_next[0]  = last_reg[1];
        end
        if (accept) begin
            cnt_next   = res_count;
            kind_next  = res_kind;
            start_next = res_start;
            end_next   = res_end;
            last_next  = {1'b1, (res_count == 2'd1)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        last_reg  <= last_next;
    end

endmodule
